FILE: rtl/att_pkg.sv
// shared types and constants of the allocation tracking table
// request, result, chain link and broadcast structs, codes and state type
// no dependencies
package att_pkg;

  localparam int SLOTS      = 64;
  localparam int SLOT_BITS  = 6;
  localparam int COUNT_BITS = 7;
  localparam int ADDR_BITS  = 32;
  localparam int SIZE_BITS  = 24;
  localparam int TOTAL_BITS = 32;
  localparam int CFG_BITS   = 32;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_BACKING   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // register indexes
  localparam logic CFG_BYTE_LIMIT  = 1'b0;
  localparam logic CFG_ENTRY_LIMIT = 1'b1;

  typedef struct packed {
    logic                 opcode;
    logic [SIZE_BITS-1:0] request_size;
    logic [ADDR_BITS-1:0] block_address;
  } att_req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [SLOT_BITS-1:0]  slot_index;
    logic [ADDR_BITS-1:0]  granted_address;
    logic [TOTAL_BITS-1:0] live_bytes;
    logic [COUNT_BITS-1:0] live_entries;
  } att_rsp_t;

  // token handed from cell to cell during a scan
  typedef struct packed {
    logic                 act;
    logic                 hit;
    logic [SLOT_BITS-1:0] idx;
    logic [SIZE_BITS-1:0] size;
  } att_link_t;

  // controls seen by every cell at once
  typedef struct packed {
    logic                 scan_alloc;
    logic                 alloc_wr;
    logic                 scan_free;
    logic [ADDR_BITS-1:0] addr;
    logic [SIZE_BITS-1:0] size;
    logic                 rel_en;
    logic [SLOT_BITS-1:0] rel_idx;
  } att_bcast_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } att_state_t;

endpackage

FILE: rtl/att_cell.sv
// one slot of the table: valid bit, address, size and a registered link stage
// depends on att_pkg
module att_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  att_pkg::att_bcast_t bc,
  input  att_pkg::att_link_t  link_in,
  output att_pkg::att_link_t  link_out
);
  import att_pkg::*;

  localparam logic [SLOT_BITS-1:0] MY_IDX = SLOT_BITS'(IDX);

  logic                 valid_r, valid_nxt;
  logic [ADDR_BITS-1:0] addr_r;
  logic [SIZE_BITS-1:0] size_r;
  att_link_t            link_r, link_nxt;
  logic                 claim, match;

  // first free slot claims, every matching slot overwrites the token
  assign claim = link_in.act && bc.scan_alloc && !link_in.hit && !valid_r;
  assign match = link_in.act && bc.scan_free && valid_r && (addr_r == bc.addr);

  always_comb begin
    link_nxt = link_in;
    if (claim) begin
      link_nxt.hit = 1'b1;
      link_nxt.idx = MY_IDX;
    end else if (match) begin
      link_nxt.hit  = 1'b1;
      link_nxt.idx  = MY_IDX;
      link_nxt.size = size_r;
    end
  end

  // valid bit: set on a committed claim, cleared by release
  always_comb begin
    valid_nxt = valid_r;
    if (claim && bc.alloc_wr) begin
      valid_nxt = 1'b1;
    end else if (bc.rel_en && (bc.rel_idx == MY_IDX)) begin
      valid_nxt = 1'b0;
    end
  end

  // valid bit and link stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      link_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      link_r  <= link_nxt;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (claim && bc.alloc_wr) begin
      addr_r <= bc.addr;
      size_r <= bc.size;
    end
  end

  assign link_out = link_r;

endmodule

FILE: rtl/att_ctrl.sv
// sequencer: request capture, limit checks, live totals, result register
// and configuration registers; depends on att_pkg
module att_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  att_pkg::att_req_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output att_pkg::att_rsp_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [att_pkg::CFG_BITS-1:0]  cfg_data,
  output att_pkg::att_link_t            head,
  input  att_pkg::att_link_t            tail,
  output att_pkg::att_bcast_t           bc
);
  import att_pkg::*;

  att_state_t            state_r, state_nxt;
  att_req_t              req_r;
  att_link_t             tail_r;
  logic                  start_r;
  logic [COUNT_BITS-1:0] live_count_r;
  logic [TOTAL_BITS-1:0] live_total_r;
  logic [TOTAL_BITS-1:0] byte_limit_r;
  logic [COUNT_BITS-1:0] entry_limit_r;
  logic                  out_valid_r, out_valid_nxt;
  att_rsp_t              out_data_r, res;
  logic                  in_accept, fin_fire, out_free, limits_ok, addr_nz;
  logic [TOTAL_BITS:0]   byte_sum;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign addr_nz   = (req_r.block_address != '0);

  // limit checks on the unwrapped byte sum
  assign byte_sum  = {1'b0, live_total_r} + (TOTAL_BITS+1)'(req_r.request_size);
  assign limits_ok = (live_count_r < entry_limit_r) && (byte_sum < {1'b0, byte_limit_r});

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshake
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    fin_fire  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (tail.act) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          fin_fire  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // token launch and broadcast controls
  always_comb begin
    head          = '0;
    head.act      = start_r;
    bc.scan_alloc = (state_r == S_SCAN) && (req_r.opcode == OP_ALLOC);
    bc.alloc_wr   = bc.scan_alloc && limits_ok && addr_nz;
    bc.scan_free  = (state_r == S_SCAN) && (req_r.opcode == OP_FREE) && addr_nz;
    bc.addr       = req_r.block_address;
    bc.size       = req_r.request_size;
    bc.rel_en     = fin_fire && (req_r.opcode == OP_FREE) && tail_r.hit;
    bc.rel_idx    = tail_r.idx;
  end

  // result of the finished scan
  always_comb begin
    res                 = '0;
    res.live_bytes      = live_total_r;
    res.live_entries    = live_count_r;
    if (req_r.opcode == OP_ALLOC) begin
      if (!limits_ok || !tail_r.hit) begin
        res.status = ST_LIMIT;
      end else if (!addr_nz) begin
        res.status = ST_BACKING;
      end else begin
        res.status          = ST_OK;
        res.slot_index      = tail_r.idx;
        res.granted_address = req_r.block_address;
        res.live_bytes      = live_total_r + TOTAL_BITS'(req_r.request_size);
        res.live_entries    = live_count_r + COUNT_BITS'(1);
      end
    end else begin
      if (tail_r.hit) begin
        res.status       = ST_OK;
        res.slot_index   = tail_r.idx;
        res.live_bytes   = live_total_r - TOTAL_BITS'(tail_r.size);
        res.live_entries = live_count_r - COUNT_BITS'(1);
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
  end

  assign out_valid_nxt = fin_fire ? 1'b1 : (out_valid_r && out_stall);

  // control registers, totals and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      live_count_r  <= '0;
      live_total_r  <= '0;
      byte_limit_r  <= '1;
      entry_limit_r <= COUNT_BITS'(SLOTS);
    end else begin
      start_r     <= in_accept;
      out_valid_r <= out_valid_nxt;
      if (fin_fire) begin
        live_count_r <= res.live_entries;
        live_total_r <= res.live_bytes;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_BYTE_LIMIT) begin
          byte_limit_r <= cfg_data[TOTAL_BITS-1:0];
        end else if (cfg_index == CFG_ENTRY_LIMIT) begin
          entry_limit_r <= cfg_data[COUNT_BITS-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) req_r <= in_data;
    if ((state_r == S_SCAN) && tail.act) tail_r <= tail;
    if (fin_fire) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.act |-> (state_r == S_SCAN))
    else $error("scan token left the chain outside a scan");
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == S_SCAN) && start_r)
    else $error("accepted request did not launch a scan");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_count_r <= COUNT_BITS'(SLOTS))
    else $error("live count above table size");
  a_count_change: assert property (@(posedge clk) disable iff (!rst_n)
    (live_count_r != $past(live_count_r)) |-> $past(fin_fire))
    else $error("live count changed without a finished transfer");
`endif

endmodule

FILE: rtl/allocation_tracking_table.sv
// a request is taken only while idle; its token walks the 64-cell chain and then
// the result is registered, so the table works on one request at a time
// a finished result waits in an output register while the next request is taken
// reset: synchronous active-low; clears valid bits, totals and sets limits to
// all-ones bytes and 64 entries; no clearing pass
module allocation_tracking_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  att_pkg::att_req_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output att_pkg::att_rsp_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [att_pkg::CFG_BITS-1:0] cfg_data
);
  import att_pkg::*;

  att_link_t  link [SLOTS+1];
  att_bcast_t bc;

  // sequencer
  att_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (link[0]),
    .tail      (link[SLOTS]),
    .bc        (bc)
  );

  // chain of slot cells
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    att_cell #(.IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .bc       (bc),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

endmodule

FILE: test/allocation_tracking_table_checker.sv
// transfer monitor and result checker for the allocation tracking table
// keeps its own slot table and totals, predicts each result and compares it
// depends on att_pkg
module allocation_tracking_table_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  att_pkg::att_req_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  att_pkg::att_rsp_t            out_data,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [att_pkg::CFG_BITS-1:0] cfg_data,
  output int                           results_due,
  output int                           mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import att_pkg::*;

  // predicted slot table, totals and limits
  logic                  slot_live  [SLOTS];
  logic [ADDR_BITS-1:0]  slot_addr  [SLOTS];
  logic [SIZE_BITS-1:0]  slot_bytes [SLOTS];
  logic [COUNT_BITS-1:0] live_n;
  logic [TOTAL_BITS-1:0] live_sum;
  logic [TOTAL_BITS-1:0] byte_cap;
  logic [COUNT_BITS-1:0] entry_cap;

  att_rsp_t outcome_queue[$];
  att_rsp_t want;

  initial begin
    results_due = 0;
    mismatch_count = 0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] expected,
                               input logic [31:0] seen);
    $display("%0t mismatch on %s: expected %0h, seen %0h", $realtime, what,
             expected, seen);
    mismatch_count++;
  endtask

  // applies one request to the table and returns the result it should give
  function automatic att_rsp_t book_request(input att_req_t r);
    att_rsp_t res;
    logic [TOTAL_BITS:0] sum;
    int pick;
    res = '0;
    pick = -1;
    if (r.opcode == OP_ALLOC) begin
      // byte check is made one bit wider so the sum cannot wrap
      sum = {1'b0, live_sum} + (TOTAL_BITS+1)'(r.request_size);
      if (live_n < entry_cap && sum < {1'b0, byte_cap}) begin
        for (int i = 0; i < SLOTS; i++)
          if (!slot_live[i] && pick < 0) pick = i;
        if (pick < 0) begin
          res.status = ST_LIMIT;
        end else if (r.block_address == '0) begin
          res.status = ST_BACKING;
        end else begin
          slot_live[pick]  = 1'b1;
          slot_addr[pick]  = r.block_address;
          slot_bytes[pick] = r.request_size;
          live_n   = live_n + COUNT_BITS'(1);
          live_sum = live_sum + TOTAL_BITS'(r.request_size);
          res.status = ST_OK;
          res.slot_index = SLOT_BITS'(pick);
          res.granted_address = r.block_address;
        end
      end else begin
        res.status = ST_LIMIT;
      end
    end else begin
      // highest matching slot wins, address zero never matches
      if (r.block_address != '0)
        for (int i = 0; i < SLOTS; i++)
          if (slot_live[i] && slot_addr[i] == r.block_address) pick = i;
      if (pick < 0) begin
        res.status = ST_NOT_FOUND;
      end else begin
        slot_live[pick] = 1'b0;
        live_n   = live_n - COUNT_BITS'(1);
        live_sum = live_sum - TOTAL_BITS'(slot_bytes[pick]);
        res.status = ST_OK;
        res.slot_index = SLOT_BITS'(pick);
      end
    end
    res.live_bytes = live_sum;
    res.live_entries = live_n;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      // state after reset
      for (int i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
      live_n = '0;
      live_sum = '0;
      byte_cap = '1;
      entry_cap = COUNT_BITS'(SLOTS);
      outcome_queue.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BYTE_LIMIT: begin
            byte_cap = cfg_data[TOTAL_BITS-1:0];
          end
          CFG_ENTRY_LIMIT: begin
            entry_cap = cfg_data[COUNT_BITS-1:0];
          end
        endcase
      end
      // result transfers against the oldest prediction
      if (out_valid && !out_stall) begin
        if (outcome_queue.size() == 0) begin
          flag_mismatch("result with none due", '0, 32'(out_data.status));
        end else begin
          want = outcome_queue.pop_front();
          if (out_data.status !== want.status)
            flag_mismatch("status", 32'(want.status), 32'(out_data.status));
          if (out_data.slot_index !== want.slot_index)
            flag_mismatch("slot_index", 32'(want.slot_index), 32'(out_data.slot_index));
          if (out_data.granted_address !== want.granted_address)
            flag_mismatch("granted_address", want.granted_address,
                          out_data.granted_address);
          if (out_data.live_bytes !== want.live_bytes)
            flag_mismatch("live_bytes", want.live_bytes, out_data.live_bytes);
          if (out_data.live_entries !== want.live_entries)
            flag_mismatch("live_entries", 32'(want.live_entries),
                          32'(out_data.live_entries));
        end
      end
      // request transfers
      if (in_valid && !in_stall) outcome_queue.push_back(book_request(in_data));
    end
    results_due <= outcome_queue.size();
  end

endmodule

FILE: test/allocation_tracking_table_test.sv
// top of the allocation tracking table testbench: clock, reset, requests,
// register writes, result-side stalls, watchdog and verdict
// depends on att_pkg, allocation_tracking_table and its checker
module allocation_tracking_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import att_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  att_req_t            in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  att_rsp_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic                cfg_index = CFG_BYTE_LIMIT;
  logic [CFG_BITS-1:0] cfg_data = '0;

  int results_due;
  int mismatch_count;
  int idle_cycles;
  bit calm = 1'b0;
  bit hold_results = 1'b0;
  logic [ADDR_BITS-1:0] addr_pool[$];

  always #10 clk = ~clk;

  allocation_tracking_table DUT (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  allocation_tracking_table_checker checker_inst (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .results_due,
    .mismatch_count
  );

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  function automatic att_req_t req(input logic op, input logic [SIZE_BITS-1:0] size,
                                   input logic [ADDR_BITS-1:0] addr);
    att_req_t r;
    r.opcode = op;
    r.request_size = size;
    r.block_address = addr;
    return r;
  endfunction

  // one request transfer, valid stays up when no gap follows
  task automatic send(input att_req_t item);
    int gap;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // register write transfer, valid is lowered by the caller
  task automatic write_register(input logic index, input logic [CFG_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_limits(input logic [CFG_BITS-1:0] bytes, input int entries);
    write_register(CFG_BYTE_LIMIT, bytes);
    write_register(CFG_ENTRY_LIMIT, CFG_BITS'(entries));
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // random request: an alloc at the given percentage, else a free, mostly of an address handed out earlier
  task automatic send_random(input int alloc_pct, input int size_max);
    att_req_t item;
    int roll;
    int pick;
    item = '0;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) begin
      item.opcode = OP_ALLOC;
      if ($urandom_range(0, 3) == 0) item.request_size = SIZE_BITS'($urandom());
      else item.request_size = SIZE_BITS'($urandom_range(0, size_max));
      roll = $urandom_range(0, 99);
      if (roll < 8) item.block_address = '0;
      else if (roll < 18 && addr_pool.size() > 0)
        item.block_address = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
      else item.block_address = $urandom();
      if (item.block_address != '0 && addr_pool.size() < 200)
        addr_pool.push_back(item.block_address);
    end else begin
      item.opcode = OP_FREE;
      item.request_size = SIZE_BITS'($urandom());
      roll = $urandom_range(0, 99);
      if (roll < 80 && addr_pool.size() > 0) begin
        pick = $urandom_range(0, addr_pool.size() - 1);
        item.block_address = addr_pool[pick];
        if ($urandom_range(0, 3) != 0) addr_pool.delete(pick);
      end else if (roll < 90) begin
        item.block_address = '0;
      end else begin
        item.block_address = $urandom();
      end
    end
    send(item);
  endtask

  // result side: random stalls, one long hold when asked
  initial begin
    int stall_len;
    forever begin
      if (hold_results) begin
        stall_len = HOLD_CYCLES;
        hold_results = 1'b0;
      end else begin
        stall_len = pick_gap();
      end
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int count;
    int alloc_pct;
    int size_max;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, backing failure, extremes, duplicates
    send(req(OP_FREE, '0, '0));
    send(req(OP_FREE, '1, 32'hDEAD_BEEF));
    send(req(OP_ALLOC, '0, '0));
    send(req(OP_ALLOC, '1, '1));
    send(req(OP_ALLOC, 24'd1, 32'h0000_0001));
    send(req(OP_ALLOC, 24'd5, '1));
    send(req(OP_FREE, '0, '1));
    send(req(OP_ALLOC, '0, 32'h1234_5678));
    send(req(OP_FREE, '0, '0));
    send(req(OP_ALLOC, 24'hAA_AAAA, 32'h5555_5555));
    send(req(OP_ALLOC, 24'h55_5555, 32'hAAAA_AAAA));
    send(req(OP_FREE, '1, '1));
    send(req(OP_FREE, '0, 32'h0000_0001));
    send(req(OP_FREE, '0, 32'h1234_5678));
    send(req(OP_FREE, '0, 32'h5555_5555));
    send(req(OP_FREE, '0, 32'hAAAA_AAAA));
    send(req(OP_FREE, '0, 32'hAAAA_AAAA));
    drain();

    // tight limits: byte boundary and entry boundary
    set_limits(32'd100, 2);
    send(req(OP_ALLOC, 24'd50, 32'h0000_1000));
    send(req(OP_ALLOC, 24'd49, 32'h0000_2000));
    send(req(OP_ALLOC, 24'd0, 32'h0000_3000));
    send(req(OP_FREE, '0, 32'h0000_1000));
    send(req(OP_ALLOC, 24'd51, 32'h0000_4000));
    send(req(OP_ALLOC, 24'd50, 32'h0000_5000));
    send(req(OP_FREE, '0, 32'h0000_2000));
    send(req(OP_FREE, '0, 32'h0000_5000));
    drain();

    // random phases, each under its own limits
    for (int phase = 0; phase < 8; phase++) begin
      calm = 1'b0;
      count = 100;
      alloc_pct = 50;
      size_max = 24'hFF_FFFF;
      case (phase)
        0: begin
          set_limits('1, 64);
          alloc_pct = 80;
          count = 120;
          calm = 1'b1;
          hold_results = 1'b1;
        end
        1: begin
          set_limits('1, 127);
          alloc_pct = 85;
          count = 120;
        end
        2: begin
          set_limits(32'd1000, 64);
          alloc_pct = 60;
          size_max = 300;
        end
        3: begin
          set_limits('0, 0);
          alloc_pct = 70;
          count = 30;
          send(req(OP_ALLOC, '0, '0));
        end
        4: begin
          set_limits(32'h0200_0000, 3);
          alloc_pct = 55;
        end
        5: begin
          set_limits($urandom(), $urandom_range(0, 64));
        end
        6: begin
          set_limits('1, 64);
          alloc_pct = 45;
          calm = 1'b1;
        end
        default: begin
          set_limits($urandom_range(1000, 100000), 1);
          size_max = 2000;
          count = 80;
        end
      endcase
      repeat (count) send_random(alloc_pct, size_max);
      drain();
    end

    // quiet tail for anything unexpected
    calm = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
